// ----- rtl/q24_pkg.sv -----
// Shared types and constants of the Q24.8 fixed-point ALU.
`default_nettype none

package q24_pkg;

  localparam int DataW = 32;

  typedef enum logic [3:0] {
    CMD_ADD        = 4'd0,
    CMD_SUB        = 4'd1,
    CMD_MUL        = 4'd2,
    CMD_DIV        = 4'd3,
    CMD_COMPARE    = 4'd4,
    CMD_MIN        = 4'd5,
    CMD_MAX        = 4'd6,
    CMD_FROM_INT   = 4'd7,
    CMD_FROM_FLOAT = 4'd8,
    CMD_TO_FLOAT   = 4'd9,
    CMD_TO_INT     = 4'd10,
    CMD_NONE       = 4'd15
  } cmd_e;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_DIV0 = 3'd1;
  localparam logic [2:0] ST_NAN  = 3'd2;
  localparam logic [2:0] ST_INF  = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;

  // One classified operation as it travels from the front to the back.
  typedef struct packed {
    cmd_e                    cmd;
    logic                    use_div;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic        [DataW-1:0] x;
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/q24_front.sv -----
// Front end: accepts operations, classifies them and queues them for the back end.
`default_nettype none

module q24_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [3:0]          cmd_i,
  input  wire logic signed [31:0]  operand_a_i,
  input  wire logic signed [31:0]  operand_b_i,
  input  wire logic signed [31:0]  int_value_i,
  input  wire logic [31:0]         float_bits_i,
  output logic                     op_valid_o,
  input  wire logic                op_ready_i,
  output q24_pkg::op_t             op_o
);
  import q24_pkg::*;

  op_t        queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  op_t        op_new;
  logic       push, pop;

  always_comb begin
    op_new = '0;
    if (cmd_i <= CMD_TO_INT) begin
      op_new.cmd = cmd_e'(cmd_i);
    end else begin
      op_new.cmd = CMD_NONE;
    end
    op_new.a       = operand_a_i;
    op_new.b       = operand_b_i;
    op_new.x       = (op_new.cmd == CMD_FROM_INT) ? int_value_i : float_bits_i;
    // A zero divisor is settled at once and never reaches the divider.
    op_new.use_div = (op_new.cmd == CMD_DIV) && (operand_b_i != '0);
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = queue_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/q24_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module q24_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [NUM_W-1:0]      quo_o
);
  localparam int CntW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;
  logic             start;

  assign in_ready_o  = !busy_q && !done_q;
  assign out_valid_o = done_q;
  assign quo_o       = quo_q;
  assign start       = in_valid_i && in_ready_o;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (done_q && out_ready_i) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/q24_back.sv -----
// Back end: executes queued operations in a two-stage pipeline with an iterative divider.
`default_nettype none

module q24_back #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               op_valid_i,
  output logic                    op_ready_o,
  input  wire q24_pkg::op_t       op_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      result_value_o,
  output logic [31:0]             float_result_o,
  output logic                    is_greater_o,
  output logic                    is_less_o,
  output logic                    is_equal_o,
  output logic [2:0]              status_o
);
  import q24_pkg::*;

  localparam int NumW = DataW + FRAC_BITS;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] res;
    logic        gt;
    logic        lt;
    logic        eq;
    logic [2:0]  st;
    logic        fsign;
    logic [31:0] fmag;
    logic [4:0]  fp;
  } exec_t;

  exec_t s1_q, s1_d, s1_op;
  logic  s1_valid_q;
  logic  out_free, s1_free, s1_adv, s1_from_op, s1_load;

  // Divider hookup.
  logic            div_in_valid, div_in_ready, div_out_valid, div_take;
  logic            div_neg_q;
  logic [31:0]     a_mag, b_mag;
  logic [NumW-1:0] div_quo;
  logic [31:0]     div_res;

  assign a_mag = op_i.a[31] ? 32'(-op_i.a) : op_i.a;
  assign b_mag = op_i.b[31] ? 32'(-op_i.b) : op_i.b;

  q24_div #(
    .NUM_W(NumW),
    .DEN_W(DataW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (div_in_valid),
    .in_ready_o (div_in_ready),
    .num_i      ({a_mag, {FRAC_BITS{1'b0}}}),
    .den_i      (b_mag),
    .out_valid_o(div_out_valid),
    .out_ready_i(s1_free),
    .quo_o      (div_quo)
  );

  assign out_free     = !out_valid_o || out_ready_i;
  assign s1_free      = !s1_valid_q || out_free;
  assign s1_adv       = s1_valid_q && out_free;
  assign div_in_valid = op_valid_i && op_i.use_div;
  // While a divide is in flight, later operations wait so that order is kept.
  assign op_ready_o   = op_i.use_div ? div_in_ready : (s1_free && div_in_ready);
  assign s1_from_op   = op_valid_i && !op_i.use_div && div_in_ready && s1_free;
  assign div_take     = div_out_valid && s1_free;
  assign s1_load      = s1_from_op || div_take;
  assign div_res      = div_neg_q ? 32'(-div_quo[31:0]) : div_quo[31:0];

  always_ff @(posedge clk_i) begin
    if (div_in_valid && div_in_ready) begin
      div_neg_q <= op_i.a[31] ^ op_i.b[31];
    end
  end

  // Stage one: everything but the final float rounding.
  logic signed [63:0] prod;
  logic        [7:0]  ff_ex, ff_eff;
  logic        [22:0] ff_fr;
  logic        [23:0] ff_mant;
  logic signed [9:0]  ff_sh, ff_n;
  logic        [63:0] ff_mag;

  assign prod = op_i.a * op_i.b;

  always_comb begin
    s1_op     = '0;
    s1_op.cmd = op_i.cmd;
    ff_ex     = op_i.x[30:23];
    ff_fr     = op_i.x[22:0];
    ff_eff    = (ff_ex == 8'd0) ? 8'd1 : ff_ex;
    ff_mant   = {(ff_ex != 8'd0), ff_fr};
    ff_sh     = $signed({2'b00, ff_eff}) - 10'sd150 + 10'(FRAC_BITS);
    ff_n      = -ff_sh;
    ff_mag    = '0;
    if (ff_sh >= 0) begin
      if (ff_sh > 10'sd31) begin
        ff_mag = 64'h1_0000_0000;
      end else begin
        ff_mag = {40'd0, ff_mant} << ff_sh[4:0];
      end
    end else if (ff_n < 10'sd25) begin
      ff_mag = ({40'd0, ff_mant} + (64'd1 << (ff_n[4:0] - 5'd1))) >> ff_n[4:0];
    end
    case (op_i.cmd)
      CMD_ADD:     s1_op.res = op_i.a + op_i.b;
      CMD_SUB:     s1_op.res = op_i.a - op_i.b;
      CMD_MUL:     s1_op.res = prod[FRAC_BITS+31:FRAC_BITS];
      CMD_DIV:     s1_op.st  = ST_DIV0;
      CMD_COMPARE: begin
        s1_op.gt = op_i.a > op_i.b;
        s1_op.lt = op_i.a < op_i.b;
        s1_op.eq = op_i.a == op_i.b;
      end
      CMD_MIN:      s1_op.res = (op_i.a <= op_i.b) ? op_i.a : op_i.b;
      CMD_MAX:      s1_op.res = (op_i.a >= op_i.b) ? op_i.a : op_i.b;
      CMD_FROM_INT: s1_op.res = op_i.x << FRAC_BITS;
      CMD_TO_INT:   s1_op.res = 32'(op_i.a >>> FRAC_BITS);
      CMD_FROM_FLOAT: begin
        if (ff_ex == 8'hFF) begin
          s1_op.st = (ff_fr != '0) ? ST_NAN : ST_INF;
        end else if (op_i.x[31]) begin
          if (ff_mag > 64'h8000_0000) begin
            s1_op.st  = ST_SAT;
            s1_op.res = 32'h8000_0000;
          end else begin
            s1_op.res = 32'(-ff_mag[31:0]);
          end
        end else if (ff_mag > 64'h7FFF_FFFF) begin
          s1_op.st  = ST_SAT;
          s1_op.res = 32'h7FFF_FFFF;
        end else begin
          s1_op.res = ff_mag[31:0];
        end
      end
      CMD_TO_FLOAT: begin
        s1_op.fsign = op_i.a[31];
        s1_op.fmag  = a_mag;
        for (int i = 0; i < 32; i++) begin
          if (a_mag[i]) begin
            s1_op.fp = 5'(i);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    s1_d = s1_q;
    if (div_take) begin
      s1_d     = '0;
      s1_d.cmd = CMD_DIV;
      s1_d.res = div_res;
    end else if (s1_from_op) begin
      s1_d = s1_op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // Stage two: shift and round to nearest even for the float result.
  logic [5:0]  tf_pe;
  logic [3:0]  tf_k;
  logic [31:0] tf_rem, tf_half;
  logic [55:0] tf_wide;
  logic [24:0] tf_m;
  logic [7:0]  tf_exp;
  logic [31:0] tf_bits;

  always_comb begin
    tf_pe   = {1'b0, s1_q.fp};
    tf_k    = '0;
    tf_rem  = '0;
    tf_half = '0;
    tf_wide = '0;
    tf_m    = '0;
    if (s1_q.fp <= 5'd23) begin
      tf_wide = {24'd0, s1_q.fmag} << (5'd23 - s1_q.fp);
      tf_m    = tf_wide[24:0];
    end else begin
      tf_k    = 4'(s1_q.fp - 5'd23);
      tf_rem  = s1_q.fmag & ((32'd1 << tf_k) - 32'd1);
      tf_half = 32'd1 << (tf_k - 4'd1);
      tf_m    = 25'(s1_q.fmag >> tf_k);
      if (tf_rem > tf_half || (tf_rem == tf_half && tf_m[0])) begin
        tf_m = tf_m + 25'd1;
      end
      if (tf_m[24]) begin
        tf_m  = tf_m >> 1;
        tf_pe = tf_pe + 6'd1;
      end
    end
    tf_exp  = 8'(tf_pe) + 8'd127 - 8'(FRAC_BITS);
    tf_bits = (s1_q.fmag == '0) ? 32'd0 : {s1_q.fsign, tf_exp, tf_m[22:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      result_value_o <= s1_q.res;
      float_result_o <= (s1_q.cmd == CMD_TO_FLOAT) ? tf_bits : 32'd0;
      is_greater_o   <= s1_q.gt;
      is_less_o      <= s1_q.lt;
      is_equal_o     <= s1_q.eq;
      status_o       <= s1_q.st;
    end
  end

  a_no_pass_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_i && op_ready_o && !op_i.use_div) |-> div_in_ready)
    else $error("operation passed a divide still in flight");

  a_one_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_from_op && div_take))
    else $error("stage one loaded from two sources");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_q)))
    else $error("stage one changed while stalled");

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.st == ST_DIV0) |-> (s1_q.res == '0))
    else $error("divide by zero with nonzero result");

endmodule

`default_nettype wire

// ----- rtl/q24_8_fixed_point_alu.sv -----
// Top level of the signed Q24.8 fixed-point ALU.
//
// One operation enters on the in channel (in_valid_i/in_ready_o) with cmd_i,
// operand_a_i, operand_b_i, int_value_i and float_bits_i, and gives exactly
// one result on the out channel (out_valid_o/out_ready_i), in order.
// The front queues up to two operations; the back runs a two-stage pipeline
// whose second stage ends in the output register, so a result passes the
// stage-one register and then the output register. A new operation can be
// taken each cycle while no divide is in flight and the output is free. A
// divide with nonzero divisor holds the bit-serial divider until stage one
// takes its quotient; operations behind it wait in the queue meanwhile.
// A divide by zero is settled at once with status 1.
// Reset empties the queue and pipeline; no state survives between operations.
// When the receiver stalls, the output register holds its result, the
// pipeline and queue fill, and in_ready_o drops once the queue is full.
`default_nettype none

module q24_8_fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         cmd_i,
  input  wire logic signed [31:0] operand_a_i,
  input  wire logic signed [31:0] operand_b_i,
  input  wire logic signed [31:0] int_value_i,
  input  wire logic [31:0]        float_bits_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      result_value_o,
  output logic [31:0]             float_result_o,
  output logic                    is_greater_o,
  output logic                    is_less_o,
  output logic                    is_equal_o,
  output logic [2:0]              status_o
);
  import q24_pkg::*;

  logic op_valid, op_ready;
  op_t  op;

  q24_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .int_value_i (int_value_i),
    .float_bits_i(float_bits_i),
    .op_valid_o  (op_valid),
    .op_ready_i  (op_ready),
    .op_o        (op)
  );

  q24_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (op_valid),
    .op_ready_o    (op_ready),
    .op_i          (op),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_value_o(result_value_o),
    .float_result_o(float_result_o),
    .is_greater_o  (is_greater_o),
    .is_less_o     (is_less_o),
    .is_equal_o    (is_equal_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire
